// ----- src/keyframe_color_interpolator_macros.svh -----
// Assertion macros used by the checker file of the keyframe color interpolator.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef KEYFRAME_COLOR_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_COLOR_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KFCI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kfci: same-cycle property violated");

// The consequent must hold in the cycle after the antecedent.
`define KFCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kfci: next-cycle property violated");

`endif

// ----- src/kfci_pkg.sv -----
// Shared constants, state encoding and control/status structs of the
// keyframe color interpolator. No dependencies.
package kfci_pkg;

    localparam int MAX_KEYS     = 64;
    localparam int NUM_BINS     = 32;
    localparam int KEY_W        = $clog2(MAX_KEYS);
    localparam int BIN_W        = $clog2(NUM_BINS);
    localparam int KEY_CNT_W    = 7;
    localparam int STAMP_W      = 24;
    localparam int CH_W         = 8;
    localparam int NUM_CH       = 4;
    localparam int COLOR_W      = CH_W * NUM_CH;
    localparam int COLOR_DEPTH  = MAX_KEYS * NUM_BINS;
    localparam int COLOR_ADDR_W = $clog2(COLOR_DEPTH);
    localparam int PROD_W       = CH_W + STAMP_W;
    localparam int STEP_W       = $clog2(CH_W);
    localparam int CH_IDX_W     = $clog2(NUM_CH);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_START,
        ST_SCAN,
        ST_COLOR_P,
        ST_COLOR_PC,
        ST_COLOR_NC,
        ST_MUL,
        ST_DIV,
        ST_CHAN_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept_write;
        logic accept_query;
        logic scan_start;
        logic scan_step;
        logic color_p;
        logic color_pc;
        logic color_nc;
        logic mul;
        logic div_step;
        logic chan_end;
        logic finish_load;
    } ctrl_t;

    typedef struct packed {
        logic trivial;
        logic scan_done;
        logic interp;
        logic div_last;
        logic chan_last;
        logic out_free;
    } stat_t;

endpackage

// ----- src/kfci_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module kfci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/kfci_ctrl.sv -----
// Sequencing state machine of the keyframe color interpolator.
// Depends on kfci_pkg for the state type and the control/status structs.
module kfci_ctrl
    import kfci_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  command,
    output logic  in_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && command == CMD_QUERY)
                begin
                    state_next = stat.trivial ? ST_FINISH : ST_SCAN_START;
                end
            end
            ST_SCAN_START: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_COLOR_P;
                end
            end
            ST_COLOR_P:  state_next = ST_COLOR_PC;
            ST_COLOR_PC: state_next = stat.interp ? ST_COLOR_NC : ST_FINISH;
            ST_COLOR_NC: state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV;
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_CHAN_END;
                end
            end
            ST_CHAN_END: state_next = stat.chan_last ? ST_FINISH : ST_MUL;
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl              = '0;
        ctrl.accept_write = (state_reg == ST_IDLE) && in_valid && (command == CMD_WRITE);
        ctrl.accept_query = (state_reg == ST_IDLE) && in_valid && (command == CMD_QUERY);
        ctrl.scan_start   = (state_reg == ST_SCAN_START);
        ctrl.scan_step    = (state_reg == ST_SCAN);
        ctrl.color_p      = (state_reg == ST_COLOR_P);
        ctrl.color_pc     = (state_reg == ST_COLOR_PC);
        ctrl.color_nc     = (state_reg == ST_COLOR_NC);
        ctrl.mul          = (state_reg == ST_MUL);
        ctrl.div_step     = (state_reg == ST_DIV);
        ctrl.chan_end     = (state_reg == ST_CHAN_END);
        ctrl.finish_load  = (state_reg == ST_FINISH) && stat.out_free;
        in_ready          = (state_reg == ST_IDLE);
    end

endmodule

// ----- src/kfci_datapath.sv -----
// Datapath of the keyframe color interpolator: keyframe memories, stamp scan,
// shared multiply and restoring divider, result and output registers.
// Depends on kfci_pkg and kfci_ram.
module kfci_datapath
    import kfci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [KEY_CNT_W-1:0] cfg_wr_data,
    input  logic [KEY_W-1:0]     key_index,
    input  logic [BIN_W-1:0]     bin_index,
    input  logic [STAMP_W-1:0]   stamp_ms,
    input  logic [CH_W-1:0]      red,
    input  logic [CH_W-1:0]      green,
    input  logic [CH_W-1:0]      blue,
    input  logic [CH_W-1:0]      alpha,
    input  logic [STAMP_W-1:0]   play_offset_ms,
    input  ctrl_t                ctrl,
    output stat_t                stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic [CH_W-1:0]      out_alpha,
    output logic                 no_keys
);

    function automatic logic [COLOR_ADDR_W-1:0] color_addr(
        input logic [KEY_W-1:0] key,
        input logic [BIN_W-1:0] bin
    );
        return COLOR_ADDR_W'(COLOR_ADDR_W'(key) * COLOR_ADDR_W'(NUM_BINS)
                             + COLOR_ADDR_W'(bin));
    endfunction

    logic [KEY_CNT_W-1:0] key_count_reg;
    logic [STAMP_W-1:0]   offset_reg;
    logic [BIN_W-1:0]     bin_reg;
    logic [KEY_CNT_W-1:0] n_reg;
    logic                 no_keys_reg;
    logic [KEY_CNT_W-1:0] rd_idx_reg;
    logic [KEY_CNT_W-1:0] reached_reg;
    logic [STAMP_W-1:0]   last_stamp_reg;
    logic [STAMP_W-1:0]   fail_stamp_reg;
    logic [STAMP_W-1:0]   elapsed_reg;
    logic [STAMP_W-1:0]   span_reg;
    logic [NUM_CH-1:0][CH_W-1:0] prev_reg;
    logic [NUM_CH-1:0][CH_W-1:0] next_reg;
    logic [NUM_CH-1:0][CH_W-1:0] result_reg;
    logic [CH_IDX_W-1:0]  ch_reg;
    logic [STEP_W-1:0]    bit_cnt_reg;
    logic [PROD_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    den_reg;
    logic [CH_W-1:0]      quo_reg;
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_no_keys_reg;

    logic [KEY_CNT_W-1:0]    n_in;
    logic                    wr_ok;
    logic [STAMP_W-1:0]      stamp_rdata;
    logic [COLOR_W-1:0]      color_rdata;
    logic [KEY_W-1:0]        stamp_raddr;
    logic [COLOR_ADDR_W-1:0] color_raddr;
    logic [KEY_CNT_W-1:0]    prev_idx;
    logic                    scan_pass;
    logic [CH_W-1:0]         cur_prev;
    logic [CH_W-1:0]         cur_next;
    logic                    neg;
    logic [CH_W-1:0]         diff;
    logic [PROD_W-1:0]       prod;
    logic                    rem_ge;
    logic [CH_W-1:0]         q_ceil;
    logic [CH_W-1:0]         blend;

    assign n_in = (key_count_reg > KEY_CNT_W'(MAX_KEYS)) ? KEY_CNT_W'(MAX_KEYS)
                                                         : key_count_reg;
    assign wr_ok = (32'(key_index) < MAX_KEYS) && (32'(bin_index) < NUM_BINS);

    // Last keyframe at or before the offset; the first one when none is.
    assign prev_idx = (reached_reg == '0) ? '0 : reached_reg - KEY_CNT_W'(1);

    assign stamp_raddr = ctrl.scan_start ? '0 : rd_idx_reg[KEY_W-1:0];
    assign color_raddr = ctrl.color_p ? color_addr(prev_idx[KEY_W-1:0], bin_reg)
                                      : color_addr(reached_reg[KEY_W-1:0], bin_reg);

    kfci_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (MAX_KEYS)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (ctrl.accept_write && wr_ok),
        .wr_addr (key_index[KEY_W-1:0]),
        .wr_data (stamp_ms),
        .rd_addr (stamp_raddr),
        .rd_data (stamp_rdata)
    );

    kfci_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (COLOR_DEPTH)
    ) u_color_ram (
        .clk     (clk),
        .wr_en   (ctrl.accept_write && wr_ok),
        .wr_addr (color_addr(key_index[KEY_W-1:0], bin_index)),
        .wr_data ({alpha, blue, green, red}),
        .rd_addr (color_raddr),
        .rd_data (color_rdata)
    );

    assign scan_pass = (offset_reg >= stamp_rdata);

    assign cur_prev = prev_reg[ch_reg];
    assign cur_next = next_reg[ch_reg];
    assign neg      = (cur_next < cur_prev);
    assign diff     = neg ? cur_prev - cur_next : cur_next - cur_prev;
    assign prod     = PROD_W'(diff) * PROD_W'(elapsed_reg);
    assign rem_ge   = (rem_reg >= den_reg);

    // A falling channel rounds its step up so the result is the floor of the
    // signed interpolation.
    assign q_ceil = CH_W'(quo_reg + CH_W'(rem_reg != '0));
    assign blend  = neg ? cur_prev - q_ceil : cur_prev + quo_reg;

    always_comb
    begin
        stat.trivial   = (n_in == '0) || (32'(bin_index) >= NUM_BINS);
        stat.scan_done = !scan_pass || (rd_idx_reg == n_reg);
        stat.interp    = (reached_reg != '0) && (reached_reg != n_reg);
        stat.div_last  = (bit_cnt_reg == STEP_W'(CH_W - 1));
        stat.chan_last = (ch_reg == CH_IDX_W'(NUM_CH - 1));
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            reached_reg   <= '0;
            ch_reg        <= '0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                key_count_reg <= cfg_wr_data;
            end

            if (ctrl.finish_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (ctrl.scan_start)
            begin
                rd_idx_reg  <= KEY_CNT_W'(1);
                reached_reg <= '0;
            end
            else if (ctrl.scan_step)
            begin
                if (scan_pass)
                begin
                    reached_reg <= rd_idx_reg;
                    rd_idx_reg  <= rd_idx_reg + KEY_CNT_W'(1);
                end
                else
                begin
                    reached_reg <= rd_idx_reg - KEY_CNT_W'(1);
                end
            end

            if (ctrl.color_nc)
            begin
                ch_reg <= '0;
            end
            else if (ctrl.chan_end)
            begin
                ch_reg <= ch_reg + CH_IDX_W'(1);
            end

            if (ctrl.mul)
            begin
                bit_cnt_reg <= '0;
            end
            else if (ctrl.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept_query)
        begin
            offset_reg  <= play_offset_ms;
            bin_reg     <= bin_index;
            n_reg       <= n_in;
            no_keys_reg <= (n_in == '0);
            result_reg  <= '0;
        end

        if (ctrl.scan_step)
        begin
            if (scan_pass)
            begin
                last_stamp_reg <= stamp_rdata;
            end
            else
            begin
                fail_stamp_reg <= stamp_rdata;
            end
        end

        if (ctrl.color_p)
        begin
            elapsed_reg <= offset_reg - last_stamp_reg;
            span_reg    <= fail_stamp_reg - last_stamp_reg;
        end

        if (ctrl.color_pc)
        begin
            prev_reg   <= color_rdata;
            result_reg <= color_rdata;
        end

        if (ctrl.color_nc)
        begin
            next_reg <= color_rdata;
        end

        // Quotient is below 256, so the divisor starts seven places up and one
        // quotient bit is settled per step.
        if (ctrl.mul)
        begin
            rem_reg <= prod;
            den_reg <= PROD_W'(span_reg) << (CH_W - 1);
            quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - den_reg;
            end
            quo_reg <= {quo_reg[CH_W-2:0], rem_ge};
            den_reg <= den_reg >> 1;
        end

        if (ctrl.chan_end)
        begin
            result_reg[ch_reg] <= blend;
        end

        if (ctrl.finish_load)
        begin
            out_color_reg   <= result_reg;
            out_no_keys_reg <= no_keys_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_color_reg[CH_W-1:0];
    assign out_green = out_color_reg[2*CH_W-1:CH_W];
    assign out_blue  = out_color_reg[3*CH_W-1:2*CH_W];
    assign out_alpha = out_color_reg[4*CH_W-1:3*CH_W];
    assign no_keys   = out_no_keys_reg;

endmodule

// ----- src/keyframe_color_interpolator.sv -----
// Channel   | handshake             | payload
// ----------+-----------------------+------------------------------------------------
// config    | cfg_wr_en             | cfg_wr_data (key_count)
// input     | in_valid / in_ready   | command, key_index, bin_index, stamp_ms, RGBA,
//           |                       | play_offset_ms
// output    | out_valid / out_ready | out_red, out_green, out_blue, out_alpha, no_keys
//
// A write transaction leaves the block idle, and it is ready again in the next cycle.
// A query scans the stamps of up to N keyframes, N being key_count capped at
// MAX_KEYS, then fetches the two colors and runs each channel through the shared
// 8x24 multiplier and 8-step restoring divider.
// Reset is asynchronous and active low; keyframe memories are not cleared.
// A finished result waits in the output register; the next transaction is taken
// while it waits, and a later result stalls only until the register frees.
// Top level of the keyframe color interpolator. Depends on kfci_pkg,
// kfci_ctrl and kfci_datapath.
module keyframe_color_interpolator
    import kfci_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [KEY_CNT_W-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [KEY_W-1:0]     key_index,
    input  logic [BIN_W-1:0]     bin_index,
    input  logic [STAMP_W-1:0]   stamp_ms,
    input  logic [CH_W-1:0]      red,
    input  logic [CH_W-1:0]      green,
    input  logic [CH_W-1:0]      blue,
    input  logic [CH_W-1:0]      alpha,
    input  logic [STAMP_W-1:0]   play_offset_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CH_W-1:0]      out_red,
    output logic [CH_W-1:0]      out_green,
    output logic [CH_W-1:0]      out_blue,
    output logic [CH_W-1:0]      out_alpha,
    output logic                 no_keys
);

    ctrl_t ctrl;
    stat_t stat;

    kfci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    kfci_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .key_index      (key_index),
        .bin_index      (bin_index),
        .stamp_ms       (stamp_ms),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .play_offset_ms (play_offset_ms),
        .ctrl           (ctrl),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .out_red        (out_red),
        .out_green      (out_green),
        .out_blue       (out_blue),
        .out_alpha      (out_alpha),
        .no_keys        (no_keys)
    );

endmodule

// ----- src/kfci_checker.sv -----
// Port-level assertions of the keyframe color interpolator, bound to the top.
// Depends on kfci_pkg and keyframe_color_interpolator_macros.svh.
`include "keyframe_color_interpolator_macros.svh"

module kfci_checker
    import kfci_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            command,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CH_W-1:0] out_red,
    input logic [CH_W-1:0] out_green,
    input logic [CH_W-1:0] out_blue,
    input logic [CH_W-1:0] out_alpha,
    input logic            no_keys
);

    logic [NUM_CH*CH_W:0] out_bundle;

    assign out_bundle = {out_red, out_green, out_blue, out_alpha, no_keys};

    // A result that is not taken stays put.
    `KFCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bundle))

    // With no keyframes in use the color is black.
    `KFCI_ASSERT_SAME(a_no_keys_black, out_valid && no_keys, out_bundle[NUM_CH*CH_W:1] == '0)

    // A write transaction never makes the block busy.
    `KFCI_ASSERT_NEXT(a_write_one_cycle, in_valid && in_ready && command == CMD_WRITE, in_ready)

    // A query transaction keeps the input side closed while it is worked on.
    `KFCI_ASSERT_NEXT(a_query_busy, in_valid && in_ready && command == CMD_QUERY, !in_ready)

endmodule

bind keyframe_color_interpolator kfci_checker u_kfci_checker (.*);
